// ===== rtl/core/i2c_master_sequencer_macros.svh =====
// assertion macros shared by the i2c master sequencer checkers
`ifndef I2C_MASTER_SEQUENCER_MACROS_SVH
`define I2C_MASTER_SEQUENCER_MACROS_SVH

// property must hold at every clock edge outside reset
`define I2CMS_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define I2CMS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== rtl/core/i2cms_pkg.sv =====
// types and constants of the i2c master sequencer
package i2cms_pkg;

    // command codes of the func field, also used as the running operation code
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;
    localparam logic [2:0] FUNC_PROBE = 3'd5;

    localparam logic [2:0] OP_IDLE = FUNC_TICK;

    localparam logic [7:0] TOP_BIT = 8'h80;

    typedef struct packed {
        logic [5:0] phase;
        logic [2:0] op;
        logic [7:0] shift;
        logic       ack;
        logic       ack_tx;
        logic       scl;
        logic       sda;
        logic [7:0] rx;
    } seq_state_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
    } seq_res_t;

endpackage

// ===== rtl/core/i2cms_step.sv =====
// next-state and result logic for one accepted word
module i2cms_step (
    input  i2cms_pkg::seq_state_t cur_state,
    input  logic [2:0]            func,
    input  logic [7:0]            byte_in,
    input  logic [6:0]            address,
    input  logic                  send_ack,
    input  logic                  sda_in,
    output i2cms_pkg::seq_state_t next_state,
    output i2cms_pkg::seq_res_t   res
);

    function automatic i2cms_pkg::seq_state_t start_fn(i2cms_pkg::seq_state_t s,
                                                       logic [5:0] k);
        i2cms_pkg::seq_state_t t;
        t = s;
        if (k == 6'd0) begin
            t.sda = 1'b1;
            t.scl = 1'b1;
        end else if (k == 6'd1) begin
            t.sda = 1'b0;
        end else begin
            t.scl = 1'b0;
        end
        return t;
    endfunction

    function automatic i2cms_pkg::seq_state_t stop_fn(i2cms_pkg::seq_state_t s,
                                                      logic [5:0] k);
        i2cms_pkg::seq_state_t t;
        t = s;
        if (k == 6'd0) begin
            t.sda = 1'b0;
            t.scl = 1'b0;
        end else if (k == 6'd1) begin
            t.scl = 1'b1;
        end else if (k == 6'd2) begin
            t.sda = 1'b1;
        end
        return t;
    endfunction

    function automatic i2cms_pkg::seq_state_t write_fn(i2cms_pkg::seq_state_t s,
                                                       logic [5:0] k, logic sda);
        i2cms_pkg::seq_state_t t;
        logic [4:0]            j;
        t = s;
        j = k[5:1];
        if (k == 6'd0) begin
            t.sda = |(s.shift & i2cms_pkg::TOP_BIT);
        end else if (k <= 6'd16) begin
            if (k[0]) begin
                t.scl = 1'b1;
            end else begin
                t.scl = 1'b0;
                if (j < 5'd8) begin
                    t.sda = |(s.shift & (i2cms_pkg::TOP_BIT >> j[2:0]));
                end else begin
                    t.sda = 1'b1;
                end
            end
        end else if (k == 6'd17) begin
            t.scl = 1'b1;
        end else if (k == 6'd18) begin
            t.ack = sda;
        end else begin
            t.scl = 1'b0;
        end
        return t;
    endfunction

    // position within each three-tick read bit slot
    function automatic logic [1:0] read_slot(logic [5:0] k);
        logic [1:0] r;
        case (k)
            6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22: r = 2'd0;
            6'd2, 6'd5, 6'd8, 6'd11, 6'd14, 6'd17, 6'd20, 6'd23: r = 2'd1;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic i2cms_pkg::seq_state_t read_fn(i2cms_pkg::seq_state_t s,
                                                      logic [5:0] k, logic sda);
        i2cms_pkg::seq_state_t t;
        logic [1:0]            r;
        t = s;
        r = read_slot(k);
        if (k == 6'd0) begin
            t.sda = 1'b1;
        end else if (k <= 6'd24) begin
            if (r == 2'd0) begin
                t.scl = 1'b1;
            end else if (r == 2'd1) begin
                t.shift = {s.shift[6:0], sda};
            end else begin
                t.scl = 1'b0;
                if (k == 6'd24) begin
                    t.sda = s.ack_tx;
                end
            end
        end else if (k == 6'd25) begin
            t.scl = 1'b1;
        end else begin
            t.scl = 1'b0;
            t.rx  = s.shift;
        end
        return t;
    endfunction

    // probe: start, address write, stop back to back
    function automatic i2cms_pkg::seq_state_t probe_fn(i2cms_pkg::seq_state_t s,
                                                       logic [5:0] p, logic sda);
        i2cms_pkg::seq_state_t t;
        logic [5:0]            kw;
        kw = p - 6'd2;
        if (p <= 6'd2) begin
            t = start_fn(s, p);
            if (p == 6'd2) begin
                t = write_fn(t, 6'd0, sda);
            end
        end else if (p <= 6'd21) begin
            t = write_fn(s, kw, sda);
            if (kw >= 6'd19) begin
                t = stop_fn(t, 6'd0);
            end
        end else begin
            t = stop_fn(s, p - 6'd21);
        end
        return t;
    endfunction

    function automatic i2cms_pkg::seq_state_t run_fn(i2cms_pkg::seq_state_t s,
                                                     logic [5:0] p, logic sda);
        i2cms_pkg::seq_state_t t;
        case (s.op)
            i2cms_pkg::FUNC_START: t = start_fn(s, p);
            i2cms_pkg::FUNC_STOP:  t = stop_fn(s, p);
            i2cms_pkg::FUNC_WRITE: t = write_fn(s, p, sda);
            i2cms_pkg::FUNC_READ:  t = read_fn(s, p, sda);
            i2cms_pkg::FUNC_PROBE: t = probe_fn(s, p, sda);
            default:               t = s;
        endcase
        return t;
    endfunction

    // last tick of each sequence
    function automatic logic fin_fn(logic [2:0] op, logic [5:0] p);
        logic f;
        case (op)
            i2cms_pkg::FUNC_START: f = (p >= 6'd2);
            i2cms_pkg::FUNC_STOP:  f = (p >= 6'd3);
            i2cms_pkg::FUNC_WRITE: f = (p >= 6'd19);
            i2cms_pkg::FUNC_READ:  f = (p >= 6'd26);
            i2cms_pkg::FUNC_PROBE: f = (p >= 6'd24);
            default:               f = 1'b1;
        endcase
        return f;
    endfunction

    logic [5:0] tick_phase;
    logic       done;

    assign tick_phase = cur_state.phase + 6'd1;

    always_comb begin
        next_state = cur_state;
        done       = 1'b0;
        if (func == i2cms_pkg::FUNC_TICK) begin
            if (cur_state.op != i2cms_pkg::OP_IDLE) begin
                next_state.phase = tick_phase;
                next_state       = run_fn(next_state, tick_phase, sda_in);
                if (fin_fn(cur_state.op, tick_phase)) begin
                    next_state.op    = i2cms_pkg::OP_IDLE;
                    next_state.phase = 6'd0;
                    done             = 1'b1;
                end
            end
        end else if (func <= i2cms_pkg::FUNC_PROBE && cur_state.op == i2cms_pkg::OP_IDLE) begin
            next_state.op    = func;
            next_state.phase = 6'd0;
            case (func)
                i2cms_pkg::FUNC_WRITE: next_state.shift = byte_in;
                i2cms_pkg::FUNC_PROBE: next_state.shift = {address, 1'b0};
                i2cms_pkg::FUNC_READ: begin
                    next_state.shift  = 8'd0;
                    next_state.ack_tx = send_ack;
                end
                default: ;
            endcase
            next_state = run_fn(next_state, 6'd0, sda_in);
        end
    end

    always_comb begin
        res.scl_out   = next_state.scl;
        res.sda_out   = next_state.sda;
        res.busy_res  = (next_state.op != i2cms_pkg::OP_IDLE);
        res.done_res  = done;
        res.read_byte = next_state.rx;
        res.ack_seen  = next_state.ack;
    end

endmodule

// ===== rtl/core/i2cms_out_buf.sv =====
// two-word result buffer between the sequencer and the result channel
module i2cms_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cms_pkg::seq_res_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cms_pkg::seq_res_t out_data
);

    i2cms_pkg::seq_res_t slot_reg [2];
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/core/i2c_master_sequencer.sv =====
// top level of the i2c master sequencer
// bit-level i2c master: every input word is either a command (start, stop, write byte,
// read byte, address probe) or one tick of the bus delay period, and every accepted word
// yields exactly one result word carrying the pin levels, busy, done, the last read byte
// and the last acknowledge seen. one word is taken per clock while s_ready is high: the sequencer
// state is updated by a single pass of logic in the cycle of acceptance and the result is
// registered in a two-word result buffer before the result channel shows it on the m_
// side, so s_ready only drops while both buffer slots hold untaken words.
// sequence lengths in ticks: start 2, stop 3, write 19, read 26, probe 24; a command
// received while a sequence runs is dropped, as are func codes six and seven
module i2c_master_sequencer (
    input  logic       aclk,
    input  logic       aresetn,
    // command / tick word
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_func,
    input  logic [7:0] s_byte_in,
    input  logic [6:0] s_address,
    input  logic       s_send_ack,
    input  logic       s_sda_in,
    // result word
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_out,
    output logic       m_sda_out,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_byte,
    output logic       m_ack_seen
);

    // sequencer state: phase counter, running op, shift register, pins and status
    i2cms_pkg::seq_state_t state_reg;
    i2cms_pkg::seq_state_t state_next;
    i2cms_pkg::seq_res_t   step_res;
    i2cms_pkg::seq_res_t   out_res;
    logic                  s_accept;

    assign s_accept = s_valid && s_ready;

    // one phase of the bus sequence per accepted word
    i2cms_step u_step (
        .cur_state  (state_reg),
        .func       (s_func),
        .byte_in    (s_byte_in),
        .address    (s_address),
        .send_ack   (s_send_ack),
        .sda_in     (s_sda_in),
        .next_state (state_next),
        .res        (step_res)
    );

    // reset: idle, both lines released, acknowledge reads as not acknowledged
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase  <= 6'd0;
            state_reg.op     <= i2cms_pkg::OP_IDLE;
            state_reg.shift  <= 8'd0;
            state_reg.ack    <= 1'b1;
            state_reg.ack_tx <= 1'b1;
            state_reg.scl    <= 1'b1;
            state_reg.sda    <= 1'b1;
            state_reg.rx     <= 8'd0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // result words wait here until the far side takes them
    i2cms_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (step_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_scl_out   = out_res.scl_out;
    assign m_sda_out   = out_res.sda_out;
    assign m_busy_res  = out_res.busy_res;
    assign m_done_res  = out_res.done_res;
    assign m_read_byte = out_res.read_byte;
    assign m_ack_seen  = out_res.ack_seen;

endmodule

// ===== rtl/core/i2cms_checker.sv =====
// port-level checks for the i2c master sequencer, bound to the top level
`include "i2c_master_sequencer_macros.svh"

module i2cms_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl_out,
    input logic       m_sda_out,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_read_byte,
    input logic       m_ack_seen
);

    // whole result payload, for the hold check
    logic [12:0] m_word;

    assign m_word = {m_scl_out, m_sda_out, m_busy_res, m_done_res, m_read_byte, m_ack_seen};

    // a finished sequence leaves the sequencer idle
    `I2CMS_ASSERT_NEVER(a_done_not_busy, m_valid && m_done_res && m_busy_res, "done while busy")

    // every accepted word is followed by a valid result word the next cycle
    `I2CMS_ASSERT_HOLDS(a_word_to_result, (s_valid && s_ready) |=> m_valid, "result word missing")

    // a stalled result word holds its payload
    `I2CMS_ASSERT_HOLDS(a_result_held, (m_valid && !m_ready) |=> (m_valid && $stable(m_word)), "stalled result changed")

endmodule

bind i2c_master_sequencer i2cms_checker u_checker (.*);
